[sv/assert_macros.svh]
// Assertion helpers for checker modules such as sara_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define CHK_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[sv/sara_pkg.sv]
`timescale 1ns / 1ps
package sara_pkg;
  localparam int ATLAS_SIZE  = 4096;
  localparam int MAX_SHELVES = 64;
  localparam int FREE_DEPTH  = 256;
  localparam int SLOT_DEPTH  = 256;
  localparam int SH_AW = $clog2(MAX_SHELVES);
  localparam int FR_AW = $clog2(FREE_DEPTH);
  localparam int SL_AW = $clog2(SLOT_DEPTH);
  localparam int CW = $clog2(ATLAS_SIZE + 1);
  localparam int BOX_W = 4 * CW;
  localparam int SHELF_W = 3 * CW;

  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_PACKED   = 3'd1;
  localparam logic [2:0] ST_FALLBACK = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_LOST     = 3'd6;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] w;
    logic [CW-1:0] h;
  } box_t;

  typedef struct packed {
    logic [CW-1:0] y;
    logic [CW-1:0] height;
    logic [CW-1:0] cursor;
  } shelf_t;
endpackage

[sv/sara_ram.sv]
`timescale 1ns / 1ps
module sara_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sv/shelf_atlas_rect_allocator_unit.sv]
`timescale 1ns / 1ps
// Time from accept to result is set by the free-list search and the shift that closes
// the gap; a release scans the slot table, and a shelf pack follows a free-list search
// that found no fit with a scan of the shelves.
// Throughput: one beat at a time; the next request is taken after the result is taken.
// Reset: synchronous active-low rst_n clears counters, slot valid bits and control;
// slot_padding returns to 2 and next_handle to 1. Memories are not cleared.
module shelf_atlas_rect_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [13:0] in_req_width,
  input  logic [13:0] in_req_height,
  input  logic [31:0] in_release_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [13:0] out_rect_x,
  output logic [13:0] out_rect_y,
  output logic [13:0] out_rect_width,
  output logic [13:0] out_rect_height,
  output logic [31:0] out_granted_handle
);
  import sara_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SLOT   = 4'd1;
  localparam logic [3:0] S_REL_RD = 4'd2;
  localparam logic [3:0] S_REL_WR = 4'd3;
  localparam logic [3:0] S_FREE   = 4'd4;
  localparam logic [3:0] S_FGET   = 4'd5;
  localparam logic [3:0] S_SHIFT  = 4'd6;
  localparam logic [3:0] S_SHELF  = 4'd7;
  localparam logic [3:0] S_PACK   = 4'd8;
  localparam logic [3:0] S_GRANT  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state_r;
  logic [5:0] pad_r;
  logic [31:0] next_handle_r;
  logic [SH_AW:0] shelf_count_r;
  logic [CW-1:0] used_height_r;
  logic [FR_AW:0] free_count_r;
  logic [SLOT_DEPTH-1:0] slot_valid_r;

  logic        cmd_r;
  logic [13:0] rw_r, rh_r;
  logic [31:0] rel_r;
  logic [CW+1:0] pw_r, ph_r;

  logic [SL_AW:0] si_r;
  logic [FR_AW:0] fi_r;
  logic [SH_AW:0] hi_r;
  logic           rd_pend_r;
  logic           found_r;
  logic [SL_AW-1:0] slot_r;
  logic [FR_AW-1:0] best_f_r;
  logic [CW-1:0]    best_key_r;
  logic [SH_AW-1:0] best_s_r;
  logic [CW-1:0]    best_h_r;
  box_t got_r;

  logic [2:0]  o_status_r;
  logic [13:0] o_x_r, o_y_r;
  logic [31:0] o_h_r;

  logic            hs_we;
  logic [SL_AW-1:0] hs_wa, hs_ra;
  logic [31:0]     hs_wd, hs_rd;
  logic            sr_we;
  logic [SL_AW-1:0] sr_wa, sr_ra;
  box_t            sr_wd, sr_rd;
  logic            fr_we;
  logic [FR_AW-1:0] fr_wa, fr_ra;
  box_t            fr_wd, fr_rd;
  logic            sh_we;
  logic [SH_AW-1:0] sh_wa, sh_ra;
  shelf_t          sh_wd, sh_rd;

  sara_ram #(.WIDTH(32), .DEPTH(SLOT_DEPTH)) u_handle (
    .clk(clk), .we(hs_we), .waddr(hs_wa), .wdata(hs_wd), .raddr(hs_ra), .rdata(hs_rd));
  sara_ram #(.WIDTH(BOX_W), .DEPTH(SLOT_DEPTH)) u_slot_rect (
    .clk(clk), .we(sr_we), .waddr(sr_wa), .wdata(sr_wd), .raddr(sr_ra), .rdata(sr_rd));
  sara_ram #(.WIDTH(BOX_W), .DEPTH(FREE_DEPTH)) u_free (
    .clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd));
  sara_ram #(.WIDTH(SHELF_W), .DEPTH(MAX_SHELVES)) u_shelf (
    .clk(clk), .we(sh_we), .waddr(sh_wa), .wdata(sh_wd), .raddr(sh_ra), .rdata(sh_rd));

  logic [CW-1:0] fkey;
  logic          ffit;
  logic          shfit;
  logic [CW:0]   half;
  logic [CW+2:0] cur_sum;
  logic [CW+2:0] uh_sum;
  logic [SL_AW-1:0] free_slot;

  assign in_ready = (state_r == S_IDLE);
  assign half = {{(CW-4){1'b0}}, pad_r[5:1]};
  assign fkey = (fr_rd.w > fr_rd.h) ? fr_rd.w : fr_rd.h;
  assign ffit = ({1'b0, fr_rd.w} >= rw_r) && ({1'b0, fr_rd.h} >= rh_r);
  assign cur_sum = {3'b000, sh_rd.cursor} + {1'b0, pw_r};
  assign shfit = ({2'b00, sh_rd.height} >= ph_r) && (cur_sum <= (CW+3)'(ATLAS_SIZE));
  assign uh_sum = {3'b000, used_height_r} + {1'b0, ph_r};

  assign hs_wa = slot_r;
  assign hs_wd = next_handle_r;
  assign sr_wa = slot_r;
  assign sr_wd = got_r;
  assign hs_we = (state_r == S_GRANT);
  assign sr_we = (state_r == S_GRANT);
  assign hs_ra = si_r[SL_AW-1:0];
  assign sr_ra = slot_r;

  always_comb begin
    free_slot = '0;
    for (int k = SLOT_DEPTH - 1; k >= 0; k--) begin
      if (!slot_valid_r[k]) free_slot = SL_AW'(k);
    end
  end

  always_comb begin
    fr_we = 1'b0;
    fr_wa = fi_r[FR_AW-1:0];
    fr_wd = fr_rd;
    fr_ra = fi_r[FR_AW-1:0];
    if (state_r == S_REL_WR) begin
      fr_we = (free_count_r < (FR_AW+1)'(FREE_DEPTH));
      fr_wa = free_count_r[FR_AW-1:0];
      fr_wd = sr_rd;
    end else if (state_r == S_SHIFT && rd_pend_r) begin
      fr_we = 1'b1;
      fr_wa = fi_r[FR_AW-1:0] - FR_AW'(2);
      fr_wd = fr_rd;
    end else if (state_r == S_FGET) begin
      fr_ra = best_f_r;
    end
  end

  always_comb begin
    sh_we = 1'b0;
    sh_wa = best_s_r;
    sh_wd = '0;
    sh_ra = hi_r[SH_AW-1:0];
    if (state_r == S_PACK) begin
      sh_we = 1'b1;
      sh_wa = best_s_r;
      sh_wd = got_r.x == '0 && found_r == 1'b0 ?
              shelf_t'{y: used_height_r, height: ph_r[CW-1:0], cursor: pw_r[CW-1:0]} :
              shelf_t'{y: got_r.y, height: best_h_r, cursor: CW'({1'b0, got_r.x} + pw_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pad_r <= 6'd2;
      next_handle_r <= 32'd1;
      shelf_count_r <= '0;
      used_height_r <= '0;
      free_count_r <= '0;
      slot_valid_r <= '0;
      rd_pend_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (cfg_we) pad_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_command;
            rw_r <= in_req_width;
            rh_r <= in_req_height;
            rel_r <= in_release_handle;
            pw_r <= (CW+2)'(in_req_width) + (CW+2)'(pad_r);
            ph_r <= (CW+2)'(in_req_height) + (CW+2)'(pad_r);
            si_r <= '0;
            rd_pend_r <= 1'b0;
            found_r <= 1'b0;
            o_x_r <= '0;
            o_y_r <= '0;
            o_h_r <= '0;
            state_r <= S_SLOT;
          end
        end
        S_SLOT: begin
          if (cmd_r == 1'b0) begin
            if (rw_r == '0 || rh_r == '0) begin
              o_status_r <= ST_INVALID;
              state_r <= S_OUT;
            end else if (&slot_valid_r) begin
              o_status_r <= ST_FALLBACK;
              state_r <= S_OUT;
            end else begin
              slot_r <= free_slot;
              fi_r <= '0;
              rd_pend_r <= 1'b0;
              found_r <= 1'b0;
              state_r <= S_FREE;
            end
          end else begin
            if (rd_pend_r && slot_valid_r[si_r[SL_AW-1:0] - SL_AW'(1)] && hs_rd == rel_r) begin
              slot_r <= si_r[SL_AW-1:0] - SL_AW'(1);
              state_r <= S_REL_RD;
            end else if (si_r == (SL_AW+1)'(SLOT_DEPTH)) begin
              if (rd_pend_r) begin
                o_status_r <= ST_NOTFOUND;
                state_r <= S_OUT;
              end else begin
                rd_pend_r <= 1'b1;
              end
            end else begin
              si_r <= si_r + 1'b1;
              rd_pend_r <= 1'b1;
            end
            if (si_r == (SL_AW+1)'(SLOT_DEPTH) && !rd_pend_r) si_r <= si_r;
          end
        end
        S_REL_RD: begin
          slot_valid_r[slot_r] <= 1'b0;
          state_r <= S_REL_WR;
        end
        S_REL_WR: begin
          if (free_count_r < (FR_AW+1)'(FREE_DEPTH)) begin
            free_count_r <= free_count_r + 1'b1;
            o_status_r <= ST_RELEASED;
          end else begin
            o_status_r <= ST_LOST;
          end
          state_r <= S_OUT;
        end
        S_FREE: begin
          if (rd_pend_r && ffit && (!found_r || fkey < best_key_r)) begin
            found_r <= 1'b1;
            best_f_r <= fi_r[FR_AW-1:0] - FR_AW'(1);
            best_key_r <= fkey;
          end
          if (fi_r < free_count_r) begin
            fi_r <= fi_r + 1'b1;
            rd_pend_r <= 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
            if (found_r || (rd_pend_r && ffit)) begin
              state_r <= S_FGET;
            end else begin
              hi_r <= '0;
              found_r <= 1'b0;
              state_r <= S_SHELF;
            end
          end
        end
        S_FGET: begin
          fi_r <= {1'b0, best_f_r} + 1'b1;
          rd_pend_r <= 1'b0;
          state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          if (!rd_pend_r) begin
            got_r <= fr_rd;
            fi_r <= fi_r + 1'b1;
            rd_pend_r <= 1'b1;
          end else if (fi_r <= free_count_r) begin
            fi_r <= fi_r + 1'b1;
          end else begin
            free_count_r <= free_count_r - 1'b1;
            o_status_r <= ST_FREE;
            state_r <= S_GRANT;
          end
          if (!rd_pend_r) o_status_r <= ST_FREE;
        end
        S_SHELF: begin
          if (rd_pend_r && shfit && (!found_r || sh_rd.height < best_h_r)) begin
            found_r <= 1'b1;
            best_s_r <= hi_r[SH_AW-1:0] - SH_AW'(1);
            best_h_r <= sh_rd.height;
            got_r <= box_t'{x: sh_rd.cursor, y: sh_rd.y, w: pw_r[CW-1:0], h: ph_r[CW-1:0]};
          end
          if (pw_r > (CW+2)'(ATLAS_SIZE) || ph_r > (CW+2)'(ATLAS_SIZE)) begin
            o_status_r <= ST_FALLBACK;
            state_r <= S_OUT;
          end else if (hi_r < shelf_count_r) begin
            hi_r <= hi_r + 1'b1;
            rd_pend_r <= 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
            if (found_r || (rd_pend_r && shfit)) begin
              o_status_r <= ST_PACKED;
              state_r <= S_PACK;
            end else if (shelf_count_r >= (SH_AW+1)'(MAX_SHELVES) ||
                         uh_sum > (CW+3)'(ATLAS_SIZE)) begin
              o_status_r <= ST_FALLBACK;
              state_r <= S_OUT;
            end else begin
              best_s_r <= shelf_count_r[SH_AW-1:0];
              got_r <= box_t'{x: '0, y: used_height_r, w: pw_r[CW-1:0], h: ph_r[CW-1:0]};
              o_status_r <= ST_PACKED;
              state_r <= S_PACK;
            end
          end
        end
        S_PACK: begin
          if (!found_r) begin
            shelf_count_r <= shelf_count_r + 1'b1;
            used_height_r <= uh_sum[CW-1:0];
          end
          state_r <= S_GRANT;
        end
        S_GRANT: begin
          slot_valid_r[slot_r] <= 1'b1;
          o_h_r <= next_handle_r;
          o_x_r <= 14'({1'b0, got_r.x} + half);
          o_y_r <= 14'({1'b0, got_r.y} + half);
          next_handle_r <= (next_handle_r == 32'hFFFF_FFFF) ? 32'd1 : next_handle_r + 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign out_status = o_status_r;
  assign out_rect_x = o_x_r;
  assign out_rect_y = o_y_r;
  assign out_granted_handle = o_h_r;
  assign out_rect_width = (o_status_r == ST_FREE || o_status_r == ST_PACKED) ? rw_r : '0;
  assign out_rect_height = (o_status_r == ST_FREE || o_status_r == ST_PACKED) ? rh_r : '0;
endmodule

[sv/sara_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sara_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_granted_handle
);
  import sara_pkg::*;

  logic granted;
  logic failed;

  assign granted = out_valid && (out_status == ST_FREE || out_status == ST_PACKED);
  assign failed = out_valid && !granted;

  `CHK_IMPL(a_out_hold, clk, rst_n, out_valid && !out_ready, 1'b1 ##1 out_valid, "result dropped")
  `CHK_IMPL(a_one_at_time, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
  `CHK_IMPL(a_handle_zero, clk, rst_n, failed, out_granted_handle == 32'd0, "handle on failure")
  `CHK_IMPL(a_handle_nz, clk, rst_n, granted, out_granted_handle != 32'd0, "zero handle")
  `CHK_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
endmodule

bind shelf_atlas_rect_allocator_unit sara_checker u_sara_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_granted_handle(out_granted_handle));
